// ----- sv/fletcher4_four_lane_checksum_core_defines.svh -----
// Assertion macros for the four-lane Fletcher-4 checksum core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef FLETCHER4_FOUR_LANE_CHECKSUM_CORE_DEFINES_SVH
`define FLETCHER4_FOUR_LANE_CHECKSUM_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent is checked at the same edge as the antecedent.
`define FL4_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fl4 assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define FL4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fl4 assertion failed");

`else

`define FL4_ASSERT_SAME(label, ante, cons)
`define FL4_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- sv/fl4_pkg.sv -----
package fl4_pkg;

	localparam int LANE_COUNT = 4;

	typedef logic [31:0] word_t;
	typedef logic [63:0] sum_t;

	// Weighted partial sums of the merge, one register stage before the final adds.
	typedef struct packed {
		sum_t a_all;
		sum_t b_from_a;
		sum_t b_from_b;
		sum_t c_from_a;
		sum_t c_from_b;
		sum_t c_from_c;
		sum_t d_from_a;
		sum_t d_from_b;
		sum_t d_from_c;
		sum_t d_from_d;
	} merge_part_t;

	// Reverses the four bytes of a 32-bit word.
	function automatic word_t bswap32(input word_t w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

// ----- sv/fletcher4_four_lane_checksum_core.sv -----
// Four-lane Fletcher-4 checksum core.
//
// Input channel: in_valid / in_stall with word_0 .. word_3, start_flag and last_flag.
// An item is taken at a clock edge where in_valid is high and in_stall is low.
// Word i of an item is added to lane i. start_flag clears all lanes before the item
// is added; last_flag makes the core emit the merged checksum (sum_a .. sum_d) after
// the item is added. Items without last_flag produce no result.
// Output channel: out_valid / out_stall; a result is taken when out_valid is high and
// out_stall is low. Configuration: cfg_valid / cfg_ready / cfg_data sets byte_swap,
// which reverses the bytes of every word before it is added. cfg_ready is always high.
//
// Throughput is one item per clock while in_stall is low. The lane update (four
// cascaded 64-bit adds per lane) is combinational between the input register and
// the lane registers. A result reaches the output in order: its last item lands in
// the input register at the accepting edge, then the lane update, the weighted partial
// sums and the final merge adds into the output register write their registers in turn.
// Reset clears all lane sums, byte_swap and every valid flag.
// When the receiver stalls, checksums queue up in the merge, partial-sum and output
// stages while other items keep flowing into the lanes. Once all three hold a checksum
// and another item sits in the input register, in_stall rises until a result leaves.
`include "fletcher4_four_lane_checksum_core_defines.svh"

module fletcher4_four_lane_checksum_core
	import fl4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] word_0,
	input  logic [31:0] word_1,
	input  logic [31:0] word_2,
	input  logic [31:0] word_3,
	input  logic        start_flag,
	input  logic        last_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] sum_a,
	output logic [63:0] sum_b,
	output logic [63:0] sum_c,
	output logic [63:0] sum_d
);

	// Configuration register.
	logic byte_swap_q;

	// Stage 1: input register.
	logic  valid_s1;
	word_t word_s1 [LANE_COUNT];
	logic  start_s1;
	logic  last_s1;

	// Lane state: four cascaded running sums per lane.
	sum_t lane_a_q [LANE_COUNT];
	sum_t lane_b_q [LANE_COUNT];
	sum_t lane_c_q [LANE_COUNT];
	sum_t lane_d_q [LANE_COUNT];
	sum_t lane_a_nxt [LANE_COUNT];
	sum_t lane_b_nxt [LANE_COUNT];
	sum_t lane_c_nxt [LANE_COUNT];
	sum_t lane_d_nxt [LANE_COUNT];
	word_t word_in [LANE_COUNT];

	// Stage 2: a last item has been folded into the lanes and waits to be merged.
	logic merge_s2;

	// Stage 3: weighted partial sums.
	logic        valid_s3;
	merge_part_t part_s3;
	merge_part_t part_nxt;

	// Stage 4: output register.
	logic valid_s4;
	sum_t sum_a_s4;
	sum_t sum_b_s4;
	sum_t sum_c_s4;
	sum_t sum_d_s4;

	// Flow control, from the output back toward the input.
	logic free_s4;
	logic free_s3;
	logic free_s2;
	logic free_s1;
	logic adv_s3;
	logic adv_s2;
	logic lane_upd;
	logic in_take;

	assign free_s4  = !valid_s4 || !out_stall;
	assign adv_s3   = valid_s3 && free_s4;
	assign free_s3  = !valid_s3 || free_s4;
	assign adv_s2   = merge_s2 && free_s3;
	assign free_s2  = !merge_s2 || free_s3;
	assign lane_upd = valid_s1 && free_s2;
	assign free_s1  = !valid_s1 || free_s2;
	assign in_stall = !free_s1;
	assign in_take  = in_valid && free_s1;

	assign cfg_ready = 1'b1;

	assign word_in[0] = word_0;
	assign word_in[1] = word_1;
	assign word_in[2] = word_2;
	assign word_in[3] = word_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_swap_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			byte_swap_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			for (int i = 0; i < LANE_COUNT; i++) begin
				word_s1[i] <= word_in[i];
			end
			start_s1 <= start_flag;
			last_s1  <= last_flag;
		end
	end

	// Lane update: optional clear, optional byte swap, then the four cascaded adds.
	always_comb begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			sum_t  base_a;
			sum_t  base_b;
			sum_t  base_c;
			sum_t  base_d;
			word_t w;
			base_a = start_s1 ? '0 : lane_a_q[i];
			base_b = start_s1 ? '0 : lane_b_q[i];
			base_c = start_s1 ? '0 : lane_c_q[i];
			base_d = start_s1 ? '0 : lane_d_q[i];
			w = byte_swap_q ? bswap32(word_s1[i]) : word_s1[i];
			lane_a_nxt[i] = base_a + {32'd0, w};
			lane_b_nxt[i] = base_b + lane_a_nxt[i];
			lane_c_nxt[i] = base_c + lane_b_nxt[i];
			lane_d_nxt[i] = base_d + lane_c_nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_COUNT; i++) begin
				lane_a_q[i] <= '0;
				lane_b_q[i] <= '0;
				lane_c_q[i] <= '0;
				lane_d_q[i] <= '0;
			end
		end else if (lane_upd) begin
			for (int i = 0; i < LANE_COUNT; i++) begin
				lane_a_q[i] <= lane_a_nxt[i];
				lane_b_q[i] <= lane_b_nxt[i];
				lane_c_q[i] <= lane_c_nxt[i];
				lane_d_q[i] <= lane_d_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_s2 <= 1'b0;
		end else if (free_s2) begin
			merge_s2 <= lane_upd && last_s1;
		end
	end

	// Weighted partial sums. Constant weights are built from shifts and adds.
	always_comb begin
		part_nxt.a_all = lane_a_q[0] + lane_a_q[1] + lane_a_q[2] + lane_a_q[3];

		// B = -a1 - 2a2 - 3a3 + 4 * sum(b)
		part_nxt.b_from_a = '0 - (lane_a_q[1] + (lane_a_q[2] << 1)
			+ lane_a_q[3] + (lane_a_q[3] << 1));
		part_nxt.b_from_b = (lane_b_q[0] + lane_b_q[1] + lane_b_q[2] + lane_b_q[3]) << 2;

		// C = a2 + 3a3 - (6b0 + 10b1 + 14b2 + 18b3) + 16 * sum(c)
		part_nxt.c_from_a = lane_a_q[2] + lane_a_q[3] + (lane_a_q[3] << 1);
		part_nxt.c_from_b = '0 - (((lane_b_q[0] << 2) + (lane_b_q[0] << 1))
			+ ((lane_b_q[1] << 3) + (lane_b_q[1] << 1))
			+ ((lane_b_q[2] << 4) - (lane_b_q[2] << 1))
			+ ((lane_b_q[3] << 4) + (lane_b_q[3] << 1)));
		part_nxt.c_from_c = (lane_c_q[0] + lane_c_q[1] + lane_c_q[2] + lane_c_q[3]) << 4;

		// D = -a3 + (4b0 + 10b1 + 20b2 + 34b3) - (48c0 + 64c1 + 80c2 + 96c3) + 64 * sum(d)
		part_nxt.d_from_a = '0 - lane_a_q[3];
		part_nxt.d_from_b = (lane_b_q[0] << 2)
			+ ((lane_b_q[1] << 3) + (lane_b_q[1] << 1))
			+ ((lane_b_q[2] << 4) + (lane_b_q[2] << 2))
			+ ((lane_b_q[3] << 5) + (lane_b_q[3] << 1));
		part_nxt.d_from_c = '0 - (((lane_c_q[0] << 5) + (lane_c_q[0] << 4))
			+ (lane_c_q[1] << 6)
			+ ((lane_c_q[2] << 6) + (lane_c_q[2] << 4))
			+ ((lane_c_q[3] << 6) + (lane_c_q[3] << 5)));
		part_nxt.d_from_d = (lane_d_q[0] + lane_d_q[1] + lane_d_q[2] + lane_d_q[3]) << 6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (free_s3) begin
			valid_s3 <= merge_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			part_s3 <= part_nxt;
		end
	end

	// Final merge adds into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (free_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			sum_a_s4 <= part_s3.a_all;
			sum_b_s4 <= part_s3.b_from_a + part_s3.b_from_b;
			sum_c_s4 <= part_s3.c_from_a + part_s3.c_from_b + part_s3.c_from_c;
			sum_d_s4 <= part_s3.d_from_a + part_s3.d_from_b
				+ part_s3.d_from_c + part_s3.d_from_d;
		end
	end

	assign out_valid = valid_s4;
	assign sum_a     = sum_a_s4;
	assign sum_b     = sum_b_s4;
	assign sum_c     = sum_c_s4;
	assign sum_d     = sum_d_s4;

	// A start item restarts lane 0 from its own (possibly swapped) word.
	`FL4_ASSERT_NEXT(a_start_restarts_lane, lane_upd && start_s1, lane_a_q[0] == $past(byte_swap_q ? bswap32(word_s1[0]) : word_s1[0]))
	// The lanes hold while a merge that cannot move still reads them.
	`FL4_ASSERT_SAME(a_lanes_hold_for_merge, merge_s2 && !free_s3, !lane_upd)
	// Input stall only occurs with an item sitting in the input register.
	`FL4_ASSERT_SAME(a_stall_needs_item, in_stall, valid_s1)
	// A new result only appears after a partial sum stage was full.
	`FL4_ASSERT_SAME(a_result_from_partials, $rose(out_valid), $past(valid_s3))

endmodule

// ----- test/tb_fletcher4_four_lane_checksum_core.sv -----
module tb_fletcher4_four_lane_checksum_core
	import fl4_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// The run is cut off at this many cycles.
	localparam int CYCLE_LIMIT = 400000;

	// Cycles to let pass after the last result before a register write or the end.
	// The core is four stages deep, so items without a last flag may still be in flight.
	localparam int DRAIN_CYCLES = 12;

	// One input item: four data words and the two framing flags.
	typedef struct packed {
		word_t w3;
		word_t w2;
		word_t w1;
		word_t w0;
		logic  start;
		logic  last;
	} group_t;

	// One merged checksum as it leaves the core.
	typedef struct packed {
		sum_t a;
		sum_t b;
		sum_t c;
		sum_t d;
	} checksum_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] word_0 = '0;
	logic [31:0] word_1 = '0;
	logic [31:0] word_2 = '0;
	logic [31:0] word_3 = '0;
	logic        start_flag = 1'b0;
	logic        last_flag = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] sum_a;
	logic [63:0] sum_b;
	logic [63:0] sum_c;
	logic [63:0] sum_d;

	// Items waiting to be offered, and the one currently on the input port.
	group_t      pending_groups[$];
	group_t      offered_group;

	// Checksums the core still owes us, oldest first.
	checksum_t   checksum_expected[$];

	// Our own copy of the lane sums and of the byte-swap register.
	sum_t        lane_acc1 [LANE_COUNT];
	sum_t        lane_acc2 [LANE_COUNT];
	sum_t        lane_acc3 [LANE_COUNT];
	sum_t        lane_acc4 [LANE_COUNT];
	logic        swap_mode = 1'b0;

	// Pacing knobs. When an eager flag is set, that side never idles between items.
	logic        tx_eager = 1'b0;
	logic        rx_eager = 1'b0;
	logic        rx_hold_on = 1'b0;
	int          tx_gap = 0;
	int          rx_wait = 0;

	int          mismatch_count = 0;
	int          cycle_count = 0;

	fletcher4_four_lane_checksum_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.word_0     (word_0),
		.word_1     (word_1),
		.word_2     (word_2),
		.word_3     (word_3),
		.start_flag (start_flag),
		.last_flag  (last_flag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sum_a      (sum_a),
		.sum_b      (sum_b),
		.sum_c      (sum_c),
		.sum_d      (sum_d)
	);

	always #2 clk = ~clk;

	// Clear our lane sums once at time zero, matching the reset state of the core.
	initial begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			lane_acc1[i] = '0;
			lane_acc2[i] = '0;
			lane_acc3[i] = '0;
			lane_acc4[i] = '0;
		end
	end

	// Adds one accepted item to the lane sums and, on a last item, queues the
	// merged checksum. A start item clears the lanes first. Without a start the
	// sums simply carry on, even right after a checksum was emitted.
	function automatic void accumulate_group(input group_t g);
		word_t     lane_word [LANE_COUNT];
		word_t     w;
		checksum_t res;
		sum_t      sb;
		sum_t      sc;
		sum_t      sd;
		int        i;
		lane_word[0] = g.w0;
		lane_word[1] = g.w1;
		lane_word[2] = g.w2;
		lane_word[3] = g.w3;
		for (i = 0; i < LANE_COUNT; i++) begin
			if (g.start) begin
				lane_acc1[i] = '0;
				lane_acc2[i] = '0;
				lane_acc3[i] = '0;
				lane_acc4[i] = '0;
			end
			w = lane_word[i];
			if (swap_mode) begin
				w = {w[7:0], w[15:8], w[23:16], w[31:24]};
			end
			lane_acc1[i] = lane_acc1[i] + {32'd0, w};
			lane_acc2[i] = lane_acc2[i] + lane_acc1[i];
			lane_acc3[i] = lane_acc3[i] + lane_acc2[i];
			lane_acc4[i] = lane_acc4[i] + lane_acc3[i];
		end
		if (g.last) begin
			sb = lane_acc2[0] + lane_acc2[1] + lane_acc2[2] + lane_acc2[3];
			sc = lane_acc3[0] + lane_acc3[1] + lane_acc3[2] + lane_acc3[3];
			sd = lane_acc4[0] + lane_acc4[1] + lane_acc4[2] + lane_acc4[3];
			// The lane weights undo the four-way interleave so that the result equals
			// the plain serial checksum over the whole word stream.
			res.a = lane_acc1[0] + lane_acc1[1] + lane_acc1[2] + lane_acc1[3];
			res.b = 64'd0 - lane_acc1[1] - 64'd2 * lane_acc1[2] - 64'd3 * lane_acc1[3]
				+ 64'd4 * sb;
			res.c = lane_acc1[2] + 64'd3 * lane_acc1[3]
				- 64'd6 * lane_acc2[0] - 64'd10 * lane_acc2[1]
				- 64'd14 * lane_acc2[2] - 64'd18 * lane_acc2[3]
				+ 64'd16 * sc;
			res.d = 64'd0 - lane_acc1[3]
				+ 64'd4 * lane_acc2[0] + 64'd10 * lane_acc2[1]
				+ 64'd20 * lane_acc2[2] + 64'd34 * lane_acc2[3]
				- 64'd48 * lane_acc3[0] - 64'd64 * lane_acc3[1]
				- 64'd80 * lane_acc3[2] - 64'd96 * lane_acc3[3]
				+ 64'd64 * sd;
			checksum_expected.push_back(res);
		end
	endfunction

	// Counts a failure and prints the first ten of them in full.
	function automatic void flag_mismatch(input string what, input checksum_t want,
		input checksum_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch (%s) at cycle %0d", what, cycle_count);
			$display("  expected a=%h b=%h c=%h d=%h", want.a, want.b, want.c, want.d);
			$display("  actual   a=%h b=%h c=%h d=%h", got.a, got.b, got.c, got.d);
		end
	endfunction

	// Sender. An item is offered as soon as the drawn gap has run out and stays on
	// the port unchanged until the core takes it. The prediction is made at the very
	// edge where the item is accepted.
	always @(posedge clk) begin
		group_t g;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				accumulate_group(offered_group);
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_groups.size() != 0) begin
					g = pending_groups.pop_front();
					offered_group = g;
					word_0 <= g.w0;
					word_1 <= g.w1;
					word_2 <= g.w2;
					word_3 <= g.w3;
					start_flag <= g.start;
					last_flag <= g.last;
					in_valid <= 1'b1;
					tx_gap = tx_eager ? 0 : $urandom_range(0, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Every accepted checksum is compared field by field with the oldest
	// expectation; afterwards the receiver stalls for a freshly drawn number of cycles.
	// A long hold from the pressure phase overrides everything.
	always @(posedge clk) begin
		checksum_t got;
		checksum_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.a = sum_a;
				got.b = sum_b;
				got.c = sum_c;
				got.d = sum_d;
				if (checksum_expected.size() == 0) begin
					flag_mismatch("unexpected result", '0, got);
				end else begin
					want = checksum_expected.pop_front();
					if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
						got.d !== want.d) begin
						flag_mismatch("wrong checksum", want, got);
					end
				end
				rx_wait = rx_eager ? 0 : $urandom_range(0, 11);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= rx_hold_on || (rx_wait > 0);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_group(input word_t w0, input word_t w1, input word_t w2,
		input word_t w3, input logic start, input logic last);
		group_t g;
		g.w0 = w0;
		g.w1 = w1;
		g.w2 = w2;
		g.w3 = w3;
		g.start = start;
		g.last = last;
		pending_groups.push_back(g);
	endtask

	// Data words lean toward the extremes now and then, so that carries ripple
	// through the full width of the sums.
	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Queues about n random items. Most of them form proper buffers: a start item,
	// some middle items and a last item. The rest carry random flags, which breaks
	// the framing and exercises continuation and start-with-last items.
	task automatic push_random_items(input int n);
		int count;
		int len;
		int k;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 99) < 85) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				for (k = 0; k < len; k++) begin
					push_group(pick_word(), pick_word(), pick_word(), pick_word(),
						k == 0, k == len - 1);
				end
				count += len;
			end else begin
				push_group(pick_word(), pick_word(), pick_word(), pick_word(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				count++;
			end
		end
	endtask

	// Waits until every item has gone in and every checksum has come out, then a few
	// more cycles for items without a last flag that may still be in the lanes.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_groups.size() != 0 || in_valid || checksum_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes the byte-swap register. Only called while the core is idle, so the new
	// mode applies exactly to the items that follow.
	task automatic write_swap(input logic value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		swap_mode = value;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);

		// Directed items with the reset value of the register (no swap).
		// Start and last on one item, with all-zero and all-one words.
		push_group(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
		push_group(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// A three-item buffer: start, a middle item without flags, then last.
		push_group(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F, 1'b1, 1'b0);
		push_group(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
		push_group(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1);
		// Items after a last item without a start keep adding to the old sums.
		push_group(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'h4B5A_6978, 1'b0, 1'b1);
		push_group(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004, 1'b0, 1'b0);
		push_group(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
		push_group(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b1, 1'b1);
		push_group(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1);
		wait_idle();

		// Directed items with byte swap on; asymmetric bytes show the reversal.
		write_swap(1'b1);
		@(negedge clk);
		push_group(32'h0102_0304, 32'h0506_0708, 32'h090A_0B0C, 32'h0D0E_0F10, 1'b1, 1'b1);
		push_group(32'hFFFF_FFFF, 32'h0000_00FF, 32'hFF00_0000, 32'h00FF_00FF, 1'b1, 1'b0);
		push_group(32'hA5A5_A5A5, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 1'b1);
		push_group(32'h0000_0080, 32'h8000_0000, 32'h00FF_FF00, 32'hFEDC_BA98, 1'b0, 1'b1);
		wait_idle();

		// Random items with idling on both sides.
		write_swap(1'b0);
		@(negedge clk);
		push_random_items(250);
		wait_idle();

		// Pressure: the receiver holds off for a long stretch while the sender keeps
		// offering items back to back, so the core fills up and stalls its input.
		write_swap(1'b1);
		@(negedge clk);
		tx_eager = 1'b1;
		fork
			begin
				@(posedge clk);
				rx_hold_on <= 1'b1;
				repeat (400) @(posedge clk);
				rx_hold_on <= 1'b0;
			end
		join_none
		push_random_items(250);
		wait_idle();

		// A stretch with no idling on either side.
		write_swap(1'b0);
		@(negedge clk);
		rx_eager = 1'b1;
		push_random_items(200);
		wait_idle();

		// Random idling on both sides again.
		write_swap(1'b1);
		@(negedge clk);
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		push_random_items(250);
		wait_idle();

		// Eager receiver behind an idling sender.
		write_swap(1'b0);
		@(negedge clk);
		rx_eager = 1'b1;
		push_random_items(250);
		wait_idle();

		// Eager sender in front of an idling receiver.
		write_swap(1'b1);
		@(negedge clk);
		tx_eager = 1'b1;
		rx_eager = 1'b0;
		push_random_items(200);
		wait_idle();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && checksum_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fl4_pkg.sv
sv/fletcher4_four_lane_checksum_core.sv
test/tb_fletcher4_four_lane_checksum_core.sv
